// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the descriptor matcher checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks a property on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a cause implies an effect in the next cycle.
`define CHK_NEXT(label, clk, rst_n, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);
`endif

// ===== rtl/knm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knm_pkg
// Shared constants and types of the k-nearest descriptor matcher.
// ----------------------------------------------------------------------------
package knm_pkg;
    localparam int MAX_REFERENCES = 1024;
    localparam int MAX_NEAR       = 8;
    localparam int REF_AW         = $clog2(MAX_REFERENCES);
    localparam int REF_CW         = $clog2(MAX_REFERENCES + 1);
    localparam int SLOT_AW        = (MAX_NEAR > 1) ? $clog2(MAX_NEAR) : 1;
    localparam int SLOT_CW        = $clog2(MAX_NEAR + 1);
    localparam int DIST_W         = 20;
    localparam int IDX_W          = 10;
    localparam int CFG_AW         = 1;
    localparam int CFG_DW         = 20;

    localparam logic [CFG_AW-1:0] CFG_DIST_LIMIT = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_NUM_NEAR   = 1'd1;
    localparam logic [DIST_W-1:0] RST_DIST_LIMIT = 20'd40000;
    localparam logic [3:0]        RST_NUM_NEAR   = 4'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic        restart_set;
        logic [63:0] descriptor_low;
        logic [63:0] descriptor_high;
    } t_in_item;

    typedef struct packed {
        logic              match_valid;
        logic [IDX_W-1:0]  reference_index;
        logic [DIST_W-1:0] match_distance;
        logic              last;
    } t_out_item;

    // Squared distance of two 8-byte words (max 8*65025, 19 bits).
    function automatic logic [18:0] word_dist(input logic [63:0] a, input logic [63:0] b);
        logic [18:0] s;
        logic signed [8:0] d;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            d = $signed({1'b0, a[8*k +: 8]}) - $signed({1'b0, b[8*k +: 8]});
            s = s + 19'(d * d);
        end
        return s;
    endfunction
endpackage

// ===== rtl/knm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knm_in_if / knm_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface knm_in_if import knm_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        operation;
    logic        restart_set;
    logic [63:0] descriptor_low;
    logic [63:0] descriptor_high;
    modport source (output valid, operation, restart_set, descriptor_low, descriptor_high,
                    input ready);
    modport sink   (input valid, operation, restart_set, descriptor_low, descriptor_high,
                    output ready);
endinterface

interface knm_out_if import knm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              match_valid;
    logic [IDX_W-1:0]  reference_index;
    logic [DIST_W-1:0] match_distance;
    logic              last;
    modport source (output valid, match_valid, reference_index, match_distance, last,
                    input ready);
    modport sink   (input valid, match_valid, reference_index, match_distance, last,
                    output ready);
endinterface

// ===== rtl/knm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knm_front
// Accepts items into a two-entry queue; the back end pops them.
// ----------------------------------------------------------------------------
module knm_front import knm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_pop,
    output t_in_item o_item
);
    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = i_pop && o_valid;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/knm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knm_back
// Stores references, scans them per query, keeps the k best, emits them.
// ----------------------------------------------------------------------------
module knm_back import knm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIST_W-1:0] i_dist_limit,
    input  logic [3:0]        i_num_near,
    input  logic              i_valid,
    output logic              o_pop,
    input  t_in_item          i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_item         o_item
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DIST = 3'd2,
                           S_UPD = 3'd3, S_WORST = 3'd4, S_EMIT = 3'd5;

    logic [63:0] r_mem_lo [MAX_REFERENCES];
    logic [63:0] r_mem_hi [MAX_REFERENCES];
    logic [63:0] r_rd_lo, r_rd_hi;

    logic [2:0]        r_state;
    logic [REF_CW-1:0] r_count, r_ptr;
    logic [REF_AW-1:0] r_cur;
    logic [63:0]       r_qlo, r_qhi;
    logic [SLOT_CW-1:0] r_limit, r_used, r_k;
    logic [IDX_W-1:0]  r_sidx [MAX_NEAR];
    logic [DIST_W:0]   r_sdist [MAX_NEAR];
    logic [SLOT_AW-1:0] r_worst, r_wscan;
    logic [DIST_W-1:0] r_d;
    t_out_item         r_out;
    logic              r_oval;
    logic [SLOT_CW-1:0] n_limit;
    logic [19:0]       dsum;

    assign o_valid = r_oval;
    assign o_item  = r_out;
    assign o_pop   = i_valid && (r_state == S_IDLE) && !r_oval;
    assign dsum    = 20'(word_dist(r_qlo, r_rd_lo)) + 20'(word_dist(r_qhi, r_rd_hi));

    always_comb begin
        n_limit = SLOT_CW'(i_num_near);
        if (i_num_near == 4'd0) n_limit = SLOT_CW'(1);
        if ({28'd0, i_num_near} > MAX_NEAR) n_limit = SLOT_CW'(MAX_NEAR);
    end

    always_ff @(posedge i_clk) begin
        r_rd_lo <= r_mem_lo[r_cur];
        r_rd_hi <= r_mem_hi[r_cur];
        if (o_pop && i_item.operation == OP_LOAD) begin
            if (i_item.restart_set) begin
                r_mem_lo[0] <= i_item.descriptor_low;
                r_mem_hi[0] <= i_item.descriptor_high;
            end else if (r_count < REF_CW'(MAX_REFERENCES)) begin
                r_mem_lo[r_count[REF_AW-1:0]] <= i_item.descriptor_low;
                r_mem_hi[r_count[REF_AW-1:0]] <= i_item.descriptor_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_oval  <= 1'b0;
            r_used  <= '0;
        end else begin
            // emission state drives the output register itself
            if (r_oval && i_ready && r_state != S_EMIT) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_item.operation == OP_LOAD) begin
                            if (i_item.restart_set) r_count <= REF_CW'(1);
                            else if (r_count < REF_CW'(MAX_REFERENCES))
                                r_count <= r_count + REF_CW'(1);
                        end else begin
                            r_qlo   <= i_item.descriptor_low;
                            r_qhi   <= i_item.descriptor_high;
                            r_limit <= n_limit;
                            r_used  <= '0;
                            r_ptr   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_ptr == r_count) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_cur   <= r_ptr[REF_AW-1:0];
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    // memory read data lands this cycle; distance next
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_d <= dsum;
                    if (dsum > i_dist_limit) begin
                        r_ptr   <= r_ptr + REF_CW'(1);
                        r_state <= S_SCAN;
                    end else if (r_used < r_limit) begin
                        r_sidx[r_used[SLOT_AW-1:0]]  <= IDX_W'(r_cur);
                        r_sdist[r_used[SLOT_AW-1:0]] <= {1'b0, dsum};
                        r_used  <= r_used + SLOT_CW'(1);
                        r_ptr   <= r_ptr + REF_CW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_worst <= '0;
                        r_wscan <= SLOT_AW'(1);
                        r_state <= S_WORST;
                    end
                end
                S_WORST: begin
                    // one slot compared per cycle, first largest kept
                    if (SLOT_CW'(r_wscan) < r_used && r_wscan != '0) begin
                        if (r_sdist[r_wscan] > r_sdist[r_worst]) r_worst <= r_wscan;
                        r_wscan <= r_wscan + SLOT_AW'(1);
                    end else begin
                        if ({1'b0, r_d} < r_sdist[r_worst]) begin
                            r_sidx[r_worst]  <= IDX_W'(r_cur);
                            r_sdist[r_worst] <= {1'b0, r_d};
                        end
                        r_ptr   <= r_ptr + REF_CW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_EMIT: begin
                    if (!r_oval || i_ready) begin
                        r_oval <= 1'b1;
                        if (r_used == '0) begin
                            r_out   <= '{1'b0, '0, '0, 1'b1};
                            r_state <= S_IDLE;
                        end else begin
                            r_out.match_valid     <= 1'b1;
                            r_out.reference_index <= r_sidx[r_k[SLOT_AW-1:0]];
                            r_out.match_distance  <= r_sdist[r_k[SLOT_AW-1:0]][DIST_W-1:0];
                            r_out.last            <= (r_k + SLOT_CW'(1) == r_used);
                            r_k <= r_k + SLOT_CW'(1);
                            if (r_k + SLOT_CW'(1) == r_used) r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/k_nearest_descriptor_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_descriptor_matcher
// Brute-force k-nearest matching of 16-byte descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer is a load (store a reference, optional restart of the
//            set) or a query. Loads give no result; beyond 1024 they are dropped.
//   out_ch : a query gives its kept candidates in slot order, or a single
//            no-match transfer; last marks the final transfer of a query.
//   Config : i_cfg_we/i_cfg_addr/i_cfg_data, 0 = distance limit, 1 = num_near;
//            write only while idle.
// Steps: a load is handled in the back end while it is idle. A query starts,
//   then takes each stored reference through address, registered memory read
//   and distance, plus a worst-slot search over the num_near (1..8) slots
//   for each in-range reference seen once the slots are full, then finishes
//   the scan and gives one result per cycle while out_ch is ready.
// A two-entry queue in front takes transfers while a query is scanned.
// Reset empties the set and restores the distance limit 40000 and num_near 5;
//   no clear pass is needed. A stalled receiver holds the output register and
//   the scan waits at emission; the queue then fills and in_ch ready drops.
// ----------------------------------------------------------------------------
module k_nearest_descriptor_matcher import knm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    knm_in_if.sink            in_ch,
    knm_out_if.source         out_ch,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);
    logic [DIST_W-1:0] r_dist_limit;
    logic [3:0]        r_num_near;
    t_in_item          in_item, q_item;
    t_out_item         out_item;
    logic              q_valid, q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_limit <= RST_DIST_LIMIT;
            r_num_near   <= RST_NUM_NEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIST_LIMIT: r_dist_limit <= i_cfg_data;
                CFG_NUM_NEAR:   r_num_near   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign in_item = '{in_ch.operation, in_ch.restart_set,
                       in_ch.descriptor_low, in_ch.descriptor_high};

    // front: accept and queue
    knm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_ch.valid),
        .o_ready (in_ch.ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // back: storage, scan, candidate slots, emission
    knm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dist_limit (r_dist_limit),
        .i_num_near   (r_num_near),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_item       (q_item),
        .o_valid      (out_ch.valid),
        .i_ready      (out_ch.ready),
        .o_item       (out_item)
    );

    assign out_ch.match_valid     = out_item.match_valid;
    assign out_ch.reference_index = out_item.reference_index;
    assign out_ch.match_distance  = out_item.match_distance;
    assign out_ch.last            = out_item.last;
endmodule

// ===== rtl/knm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// knm_checker
// Port-level checks of the matcher's result channel.
// ----------------------------------------------------------------------------
module knm_checker import knm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_match_valid,
    input logic [IDX_W-1:0]  out_reference_index,
    input logic [DIST_W-1:0] out_match_distance,
    input logic              out_last
);
    `CHK_ALWAYS(a_nomatch_last, i_clk, i_rst_n, !(out_valid && !out_match_valid) || out_last, "no-match not last")
    `CHK_ALWAYS(a_nomatch_zero, i_clk, i_rst_n, !(out_valid && !out_match_valid) || (out_reference_index == '0 && out_match_distance == '0), "no-match nonzero")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_reference_index), "stalled result changed")
    `CHK_NEXT(a_after_nomatch, i_clk, i_rst_n, out_valid && out_ready && !out_match_valid, !out_valid || out_match_valid || out_last, "bad sequence")
endmodule

bind k_nearest_descriptor_matcher knm_checker u_knm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_match_valid     (out_ch.match_valid),
    .out_reference_index (out_ch.reference_index),
    .out_match_distance  (out_ch.match_distance),
    .out_last            (out_ch.last)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-nearest descriptor matcher: loads and queries
// are driven over the input channel, a software-side nearest-slot predictor
// works out every candidate result, and the result channel is checked
// transfer by transfer under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import knm_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;  // idle cycles; far above any scan plus a stall
    localparam int SETTLE_CYCLES  = 20;     // lets the back end finish its last load
    localparam int STALL_CYCLES   = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    knm_in_if  in_ch ();
    knm_out_if out_ch ();

    k_nearest_descriptor_matcher u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Items waiting for the driver; head is the one on the bus.
    t_in_item  pending_items[$];
    // Candidate results still owed by the block, oldest first.
    t_out_item owed_matches[$];

    // Predictor copy of the block state.
    logic [63:0]       mdl_ref_lo [MAX_REFERENCES];
    logic [63:0]       mdl_ref_hi [MAX_REFERENCES];
    int                mdl_ref_cnt;
    logic [DIST_W-1:0] mdl_max_dist;
    logic [3:0]        mdl_num_near;

    int       snd_idle_pct;
    int       rcv_idle_pct;
    bit       stall_request;
    int       stall_left;
    int       quiet_cycles;
    int       error_cnt;
    t_in_item cur_item;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sum of squared byte differences over all 16 bytes.
    function automatic int desc_distance(input logic [127:0] a, input logic [127:0] b);
        int sum;
        int d;
        sum = 0;
        for (int k = 0; k < 16; k++) begin
            d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            sum += d * d;
        end
        return sum;
    endfunction

    // Apply one accepted transfer to the predictor; queries queue their results.
    function automatic void track_transfer(input t_in_item it);
        int        keep;
        int        used;
        int        worst;
        int        d;
        int        s_idx [MAX_NEAR];
        int        s_dist[MAX_NEAR];
        t_out_item res;
        if (it.operation == OP_LOAD) begin
            if (it.restart_set) mdl_ref_cnt = 0;
            // set full: load dropped
            if (mdl_ref_cnt < MAX_REFERENCES) begin
                mdl_ref_lo[mdl_ref_cnt] = it.descriptor_low;
                mdl_ref_hi[mdl_ref_cnt] = it.descriptor_high;
                mdl_ref_cnt++;
            end
            return;
        end
        keep = (mdl_num_near == 0) ? 1 : (mdl_num_near > MAX_NEAR) ? MAX_NEAR : mdl_num_near;
        used = 0;
        for (int r = 0; r < mdl_ref_cnt; r++) begin
            d = desc_distance({it.descriptor_high, it.descriptor_low},
                              {mdl_ref_hi[r], mdl_ref_lo[r]});
            if (d > int'(mdl_max_dist)) continue;
            if (used < keep) begin
                s_idx[used]  = r;
                s_dist[used] = d;
                used++;
            end else begin
                // first slot holding the largest distance; ties do not replace
                worst = 0;
                for (int k = 1; k < used; k++)
                    if (s_dist[k] > s_dist[worst]) worst = k;
                if (d < s_dist[worst]) begin
                    s_idx[worst]  = r;
                    s_dist[worst] = d;
                end
            end
        end
        if (used == 0) begin
            res = '0;
            res.last = 1'b1;
            owed_matches.insert(owed_matches.size(), res);
            return;
        end
        for (int k = 0; k < used; k++) begin
            res.match_valid     = 1'b1;
            res.reference_index = IDX_W'(s_idx[k]);
            res.match_distance  = DIST_W'(s_dist[k]);
            res.last            = (k == used - 1);
            owed_matches.insert(owed_matches.size(), res);
        end
    endfunction

    // Driver: valid holds until the transfer completes, then a new item or a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                track_transfer(cur_item);
                void'(pending_items.pop_front());
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    cur_item              = pending_items[0];
                    in_ch.valid           <= 1'b1;
                    in_ch.operation       <= cur_item.operation;
                    in_ch.restart_set     <= cur_item.restart_set;
                    in_ch.descriptor_low  <= cur_item.descriptor_low;
                    in_ch.descriptor_high <= cur_item.descriptor_high;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer, randomizes ready, runs the watchdog.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   = 0;
            quiet_cycles = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.match_valid     = out_ch.match_valid;
                got.reference_index = out_ch.reference_index;
                got.match_distance  = out_ch.match_distance;
                got.last            = out_ch.last;
                if (owed_matches.size() == 0) begin
                    error_cnt++;
                    $display("%0t: unexpected result, actual %p", $time, got);
                end else begin
                    want = owed_matches.pop_front();
                    if (got.match_valid !== want.match_valid ||
                        got.reference_index !== want.reference_index ||
                        got.match_distance !== want.match_distance ||
                        got.last !== want.last) begin
                        error_cnt++;
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    end
                end
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[k_nearest_descriptor_matcher] ERROR");
                $finish;
            end
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = STALL_CYCLES;
            end
            // long hold-off lets the front queue fill so in_ch ready drops
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    function automatic void push_item(input logic op, input logic rs, input logic [127:0] desc);
        t_in_item it;
        it.operation       = op;
        it.restart_set     = rs;
        it.descriptor_low  = desc[63:0];
        it.descriptor_high = desc[127:64];
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [127:0] random_desc();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Per-byte jitter around a base, clamped to the byte range.
    function automatic logic [127:0] jitter(input logic [127:0] base, input int spread);
        logic [127:0] v;
        int b;
        for (int k = 0; k < 16; k++) begin
            b = int'(base[8*k +: 8]) + $urandom_range(0, 2 * spread) - spread;
            v[8*k +: 8] = (b < 0) ? 8'd0 : (b > 255) ? 8'd255 : 8'(b);
        end
        return v;
    endfunction

    // Wait until the bench has nothing in flight, then let the back end settle.
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || owed_matches.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DIST_LIMIT) mdl_max_dist = val;
        else                       mdl_num_near = val[3:0];
    endtask

    task automatic set_config(input logic [CFG_DW-1:0] max_d, input logic [3:0] near);
        drain();
        write_reg(CFG_DIST_LIMIT, max_d);
        write_reg(CFG_NUM_NEAR, CFG_DW'(near));
    endtask

    // One reference set: restart load, clustered refs, queries near the cluster,
    // plus some noise items.
    task automatic random_set(input int n_refs, input int n_queries);
        logic [127:0] base;
        int spread;
        base   = random_desc();
        spread = $urandom_range(0, 24);
        push_item(OP_LOAD, 1'b1, jitter(base, spread));
        for (int i = 1; i < n_refs + n_queries; i++) begin
            case ($urandom_range(0, 9))
                0:       push_item(OP_LOAD, $urandom_range(0, 9) == 0, random_desc());
                1:       push_item(OP_QUERY, 1'($urandom_range(0, 1)), random_desc());
                2, 3, 4: push_item(OP_QUERY, 1'($urandom_range(0, 1)), jitter(base, spread));
                default: push_item(OP_LOAD, 1'b0, jitter(base, spread));
            endcase
        end
    endtask

    task automatic random_config();
        logic [CFG_DW-1:0] max_d;
        case ($urandom_range(0, 5))
            0:       max_d = '0;
            1:       max_d = 20'd1040400;
            2:       max_d = '1;
            default: max_d = 20'($urandom_range(0, 60000));
        endcase
        set_config(max_d, 4'($urandom_range(0, 15)));
    endtask

    initial begin
        logic [127:0] zeros;
        logic [127:0] ones;
        zeros         = '0;
        ones          = '1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.operation       = OP_LOAD;
        in_ch.restart_set     = 1'b0;
        in_ch.descriptor_low  = '0;
        in_ch.descriptor_high = '0;
        out_ch.ready  = 1'b0;
        stall_request = 1'b0;
        error_cnt     = 0;
        mdl_ref_cnt   = 0;
        mdl_max_dist  = RST_DIST_LIMIT;
        mdl_num_near  = RST_NUM_NEAR;
        snd_idle_pct  = 30;
        rcv_idle_pct  = 72;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set with restart on a query, ties, byte extremes.
        push_item(OP_QUERY, 1'b1, zeros);
        push_item(OP_LOAD, 1'b1, zeros);
        push_item(OP_LOAD, 1'b0, ones);
        push_item(OP_LOAD, 1'b0, zeros);
        push_item(OP_LOAD, 1'b0, {64'h0102030405060708, 64'h0});
        push_item(OP_LOAD, 1'b0, zeros);
        push_item(OP_LOAD, 1'b0, zeros);
        push_item(OP_LOAD, 1'b0, {124'h0, 4'h1});
        push_item(OP_QUERY, 1'b0, zeros);
        push_item(OP_QUERY, 1'b0, ones);
        push_item(OP_QUERY, 1'b0, {64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00});
        set_config(20'd1040400, 4'd8);
        push_item(OP_QUERY, 1'b0, zeros);
        push_item(OP_QUERY, 1'b0, ones);
        set_config(20'd0, 4'd0);
        push_item(OP_QUERY, 1'b0, zeros);
        set_config('1, 4'd15);
        push_item(OP_QUERY, 1'b0, {64'h8080808080808080, 64'h8080808080808080});
        set_config(20'd1, 4'd2);
        push_item(OP_QUERY, 1'b0, zeros);
        set_config(20'd40000, 4'd3);
        push_item(OP_LOAD, 1'b1, ones);
        push_item(OP_QUERY, 1'b0, ones);

        for (int phase = 0; phase < 3; phase++) begin
            drain();
            snd_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 72 : 0;
            rcv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 30 : 0;
            for (int s = 0; s < 10; s++) begin
                if (s % 3 == 0) random_config();
                if (phase == 2 && s == 4) begin
                    drain();
                    stall_request = 1'b1;
                end
                random_set($urandom_range(1, 14), $urandom_range(4, 12));
            end
        end

        // Restart after queries: the set shrinks back to one reference.
        set_config(20'd30000, 4'd4);
        push_item(OP_QUERY, 1'b0, zeros);
        push_item(OP_LOAD, 1'b1, zeros);
        push_item(OP_QUERY, 1'b0, zeros);

        drain();
        if (error_cnt == 0)
            $display("[k_nearest_descriptor_matcher] OK");
        else
            $display("[k_nearest_descriptor_matcher] ERROR");
        $finish;
    end
endmodule

// ===== k_nearest_descriptor_matcher.f =====
+incdir+rtl
rtl/knm_pkg.sv
rtl/knm_in_if.sv
rtl/knm_front.sv
rtl/knm_back.sv
rtl/k_nearest_descriptor_matcher.sv
rtl/knm_checker.sv
bench/tb_top.sv
